>>> rtl/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types, register indexes and lookup tables of the spot light
// attenuation block.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int PosW   = 20;
  localparam int DiffW  = 21;
  localparam int CfgW   = 60;
  localparam int IdxW   = 3;

  localparam logic [IdxW-1:0] REG_LIGHT_POSITION = 3'd0;
  localparam logic [IdxW-1:0] REG_LIGHT_COLOR    = 3'd1;
  localparam logic [IdxW-1:0] REG_FALLOFF_START  = 3'd2;
  localparam logic [IdxW-1:0] REG_FALLOFF_END    = 3'd3;
  localparam logic [IdxW-1:0] REG_SPOT_DIRECTION = 3'd4;
  localparam logic [IdxW-1:0] REG_SPOT_POWER     = 3'd5;

  localparam logic [59:0] LIGHT_POSITION_RST = 60'd0;
  localparam logic [47:0] LIGHT_COLOR_RST    = 48'h1000_1000_1000;
  localparam logic [19:0] FALLOFF_START_RST  = 20'd0;
  localparam logic [19:0] FALLOFF_END_RST    = 20'd2560;
  localparam logic [47:0] SPOT_DIRECTION_RST = 48'hC000_0000_0000;
  localparam logic [9:0]  SPOT_POWER_RST     = 10'd128;

  typedef enum logic [1:0] {
    FALL_ZERO,
    FALL_ONE,
    FALL_DIV
  } fall_kind_e;

  typedef enum logic [1:0] {
    CONE_ZERO,
    CONE_ONE,
    CONE_CALC
  } cone_kind_e;

  typedef struct packed {
    logic [2:0][DiffW-1:0] v;
    logic                  degen;
  } front_item_t;

  typedef struct packed {
    logic [47:0] light_color;
    logic [19:0] falloff_start;
    logic [19:0] falloff_end;
    logic [47:0] spot_direction;
    logic [9:0]  spot_power;
  } cfg_t;

  typedef struct packed {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [15:0] irr_red;
    logic [15:0] irr_green;
    logic [15:0] irr_blue;
    logic        degenerate;
  } res_item_t;

  function automatic logic [16:0] log_lut(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd0;
      5'd1:    val = 17'd5732;
      5'd2:    val = 17'd11136;
      5'd3:    val = 17'd16248;
      5'd4:    val = 17'd21098;
      5'd5:    val = 17'd25711;
      5'd6:    val = 17'd30110;
      5'd7:    val = 17'd34313;
      5'd8:    val = 17'd38336;
      5'd9:    val = 17'd42196;
      5'd10:   val = 17'd45904;
      5'd11:   val = 17'd49472;
      5'd12:   val = 17'd52911;
      5'd13:   val = 17'd56229;
      5'd14:   val = 17'd59434;
      5'd15:   val = 17'd62534;
      default: val = 17'd65536;
    endcase
    return val;
  endfunction

  function automatic logic [16:0] exp_lut(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd65536;
      5'd1:    val = 17'd62757;
      5'd2:    val = 17'd60097;
      5'd3:    val = 17'd57549;
      5'd4:    val = 17'd55109;
      5'd5:    val = 17'd52773;
      5'd6:    val = 17'd50535;
      5'd7:    val = 17'd48393;
      5'd8:    val = 17'd46341;
      5'd9:    val = 17'd44376;
      5'd10:   val = 17'd42495;
      5'd11:   val = 17'd40693;
      5'd12:   val = 17'd38968;
      5'd13:   val = 17'd37316;
      5'd14:   val = 17'd35734;
      5'd15:   val = 17'd34219;
      default: val = 17'd32768;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/sla_fifo.sv
// ----------------------------------------------------------------------------
// sla_fifo
// Small first-in first-out word queue.
// ----------------------------------------------------------------------------
module sla_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/sla_front.sv
// ----------------------------------------------------------------------------
// sla_front
// Forms the vector from the surface point to the light and flags a point
// that lies on the light.
// ----------------------------------------------------------------------------
module sla_front (
  input  logic signed [19:0]  point_x_i,
  input  logic signed [19:0]  point_y_i,
  input  logic signed [19:0]  point_z_i,
  input  logic [59:0]         light_pos_i,
  output sla_pkg::front_item_t item_o
);

  logic [2:0][19:0] pt;

  assign pt = {point_z_i, point_y_i, point_x_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      item_o.v[c] = {light_pos_i[20*c+19], light_pos_i[20*c +: 20]} -
                    {pt[c][19], pt[c]};
    end
    item_o.degen = (item_o.v == '0);
  end

endmodule

>>> rtl/sla_div.sv
// ----------------------------------------------------------------------------
// sla_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sla_div #(
  parameter int NW = 45,
  parameter int DW = 31,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [W-1:0]  rem_in, trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;

    if (s == 0) begin : g_head
      assign rem_in = W'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = W'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= trial) begin
          rem_q[s] <= rem_in - trial;
          quo_q[s] <= quo_in | (QW'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

>>> rtl/sla_back.sv
// ----------------------------------------------------------------------------
// sla_back
// Shading pipeline: distance by square root, unit vector and falloff by
// division, cone power by log2 and exp2 tables, color scaling.
// ----------------------------------------------------------------------------
module sla_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  sla_pkg::front_item_t item_i,
  input  sla_pkg::cfg_t        cfg_i,
  output logic                 out_valid_o,
  output sla_pkg::res_item_t   res_o
);

  localparam int SqW = 31;
  localparam int DvW = 16;
  localparam int Lat = 3 + SqW + 1 + DvW + 10;
  localparam int TlN = 9;

  typedef struct packed {
    logic [2:0][19:0] mag;
    logic [2:0]       neg;
    logic             degen;
  } side_a_t;

  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    sla_pkg::fall_kind_e kind;
  } side_b_t;

  typedef struct packed {
    logic [2:0][15:0] dir;
    logic [16:0]      fall;
    logic             degen;
  } tail_t;

  logic [Lat-1:0] vld_q;

  logic [2:0][19:0] mag1_q, mag1_d;
  logic [2:0]       neg1_q, neg1_d;
  logic             dg1_q;
  logic [2:0][39:0] sq2_q, sq2_d;
  side_a_t          sa2_q, sa3_q;
  logic [61:0]      x3_q, x3_d;

  logic [61:0] rt_rem_q  [SqW];
  logic [30:0] rt_root_q [SqW];
  side_a_t     rt_side_q [SqW];

  logic [2:0][44:0] dnum4_q, dnum4_d;
  logic [30:0]      dden4_q;
  logic [35:0]      fnum4_q, fnum4_d;
  logic [19:0]      fden4_q, fden4_d;
  side_b_t          sb4_q, sb4_d;
  side_b_t          dv_side_q [DvW];

  logic [2:0][15:0] quo_w;
  logic [15:0]      fquo_w;

  tail_t                tl_q [TlN];
  tail_t                tl0_d;
  logic signed [31:0]   pr6_q [3];
  logic signed [31:0]   pr6_d [3];
  logic [16:0]          a7_q, a7_d;
  sla_pkg::cone_kind_e  ck8_q, ck8_d, ck9_q, ck10_q, ck11_q;
  logic [3:0]           k8_q, k8_d, k9_q, i8_q, i8_d;
  logic [10:0]          r8_q, r8_d;
  logic [16:0]          lg9_q, lg9_d;
  logic [26:0]          e10_q, e10_d;
  logic [16:0]          x11_q, x11_d;
  logic [4:0]           n11_q, n11_d;
  logic                 big11_q, big11_d;
  logic [16:0]          g12_q, g12_d;
  logic [16:0]          att13_q, att13_d;
  sla_pkg::res_item_t   res14_q, res14_d;

  // square root, one result bit per stage
  for (genvar k = 0; k < SqW; k++) begin : g_sqrt
    localparam int B = SqW - 1 - k;
    logic [61:0] rem_in;
    logic [30:0] root_in;
    side_a_t     side_in;
    logic [62:0] trial;

    if (k == 0) begin : g_head
      assign rem_in  = x3_q;
      assign root_in = '0;
      assign side_in = sa3_q;
    end else begin : g_body
      assign rem_in  = rt_rem_q[k-1];
      assign root_in = rt_root_q[k-1];
      assign side_in = rt_side_q[k-1];
    end

    assign trial = (63'(root_in) << (B + 1)) + (63'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_side_q[k] <= side_in;
        if ({1'b0, rem_in} >= trial) begin
          rt_rem_q[k]  <= 62'({1'b0, rem_in} - trial);
          rt_root_q[k] <= root_in | (31'(1) << B);
        end else begin
          rt_rem_q[k]  <= rem_in;
          rt_root_q[k] <= root_in;
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_dir_div
    sla_div #(.NW(45), .DW(31), .QW(DvW)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (dnum4_q[c]),
      .den_i (dden4_q),
      .quo_o (quo_w[c])
    );
  end

  sla_div #(.NW(36), .DW(20), .QW(DvW)) u_fall_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (fnum4_q),
    .den_i (fden4_q),
    .quo_o (fquo_w)
  );

  always_comb begin
    logic [41:0]        d2;
    logic [30:0]        q;
    side_a_t            sa;
    logic [20:0]        d;
    logic [15:0]        u;
    side_b_t            sb;
    logic signed [33:0] dot, t;
    logic [33:0]        tp;
    logic [21:0]        tsh;
    logic [16:0]        lo, hi;
    logic [23:0]        lprod;
    logic [20:0]        lval;
    logic [4:0]         kp1;
    logic [31:0]        ep;
    logic [15:0]        f;
    logic [16:0]        ej, ej1;
    logic [23:0]        xprod;
    logic [17:0]        rnd, gsum;
    logic [33:0]        gf;
    logic [33:0]        cp;
    logic [17:0]        ch;
    logic [15:0]        am;
    logic [3:0]         msb;

    for (int c = 0; c < 3; c++) begin
      neg1_d[c] = item_i.v[c][20];
      mag1_d[c] = neg1_d[c] ? 20'(-item_i.v[c]) : item_i.v[c][19:0];
      sq2_d[c]  = 40'(mag1_q[c]) * 40'(mag1_q[c]);
    end

    d2   = 42'(sq2_q[0]) + 42'(sq2_q[1]) + 42'(sq2_q[2]);
    x3_d = {d2[41:0], 20'd0};

    q  = rt_root_q[SqW-1];
    sa = rt_side_q[SqW-1];
    d  = q[30:10];
    for (int c = 0; c < 3; c++) begin
      dnum4_d[c] = {1'b0, sa.mag[c], 24'd0} + 45'(q >> 1);
    end
    sb4_d.neg   = sa.neg;
    sb4_d.degen = sa.degen;
    if (d >= {1'b0, cfg_i.falloff_end}) begin
      sb4_d.kind = sla_pkg::FALL_ZERO;
    end else if (d <= {1'b0, cfg_i.falloff_start}) begin
      sb4_d.kind = sla_pkg::FALL_ONE;
    end else begin
      sb4_d.kind = sla_pkg::FALL_DIV;
    end
    fnum4_d = {d[19:0] - cfg_i.falloff_start, 16'd0};
    fden4_d = cfg_i.falloff_end - cfg_i.falloff_start;

    sb = dv_side_q[DvW-1];
    for (int c = 0; c < 3; c++) begin
      u = (quo_w[c] > 16'd16384) ? 16'd16384 : quo_w[c];
      tl0_d.dir[c] = sb.neg[c] ? 16'(-u) : u;
    end
    case (sb.kind)
      sla_pkg::FALL_ZERO: tl0_d.fall = 17'd0;
      sla_pkg::FALL_ONE:  tl0_d.fall = 17'd65536;
      default:            tl0_d.fall = 17'd65536 - {1'b0, fquo_w};
    endcase
    tl0_d.degen = sb.degen;

    for (int c = 0; c < 3; c++) begin
      pr6_d[c] = $signed(cfg_i.spot_direction[16*c +: 16]) * $signed(tl_q[0].dir[c]);
    end

    dot = 34'(pr6_q[0]) + 34'(pr6_q[1]) + 34'(pr6_q[2]);
    t   = -dot;
    tp  = 34'(t) + 34'd2048;
    tsh = tp[33:12];
    if (t <= 0) begin
      a7_d = 17'd0;
    end else if (tsh > 22'd65536) begin
      a7_d = 17'd65536;
    end else begin
      a7_d = tsh[16:0];
    end

    am  = a7_q[15:0];
    msb = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (am[b]) begin
        msb = 4'(b);
      end
    end
    k8_d = 4'd15 - msb;
    {i8_d, r8_d} = 15'(am << k8_d);
    if (cfg_i.spot_power == '0) begin
      ck8_d = sla_pkg::CONE_ONE;
    end else if (a7_q == '0) begin
      ck8_d = sla_pkg::CONE_ZERO;
    end else if (a7_q[16]) begin
      ck8_d = sla_pkg::CONE_ONE;
    end else begin
      ck8_d = sla_pkg::CONE_CALC;
    end

    lo    = sla_pkg::log_lut({1'b0, i8_q});
    hi    = sla_pkg::log_lut({1'b0, i8_q} + 5'd1);
    lprod = 24'(13'(hi - lo)) * 24'(r8_q);
    lg9_d = lo + 17'((lprod + 24'd1024) >> 11);

    kp1   = {1'b0, k9_q} + 5'd1;
    lval  = {kp1, 16'd0} - 21'(lg9_q);
    ep    = 32'(lval) * 32'(cfg_i.spot_power) + 32'd8;
    e10_d = ep[30:4];

    f       = e10_q[15:0];
    ej      = sla_pkg::exp_lut({1'b0, f[15:12]});
    ej1     = sla_pkg::exp_lut({1'b0, f[15:12]} + 5'd1);
    xprod   = 24'(12'(ej - ej1)) * 24'(f[11:0]);
    x11_d   = ej - 17'((xprod + 24'd2048) >> 12);
    big11_d = (e10_q[26:16] > 11'd16);
    n11_d   = e10_q[20:16];

    rnd  = (n11_q == '0) ? 18'd0 : (18'd1 << (n11_q - 5'd1));
    gsum = ({1'b0, x11_q} + rnd) >> n11_q;
    case (ck11_q)
      sla_pkg::CONE_ZERO: g12_d = 17'd0;
      sla_pkg::CONE_ONE:  g12_d = 17'd65536;
      default:            g12_d = big11_q ? 17'd0 : gsum[16:0];
    endcase

    gf      = 34'(g12_q) * 34'(tl_q[TlN-2].fall) + 34'd32768;
    att13_d = gf[32:16];

    res14_d.dir_x      = tl_q[TlN-1].dir[0];
    res14_d.dir_y      = tl_q[TlN-1].dir[1];
    res14_d.dir_z      = tl_q[TlN-1].dir[2];
    res14_d.degenerate = tl_q[TlN-1].degen;
    for (int c = 0; c < 3; c++) begin
      cp = 34'(cfg_i.light_color[16*c +: 16]) * 34'(att13_q) + 34'd32768;
      ch = cp[33:16];
      if (tl_q[TlN-1].degen) begin
        ch = 18'd0;
      end
      case (c)
        0:       res14_d.irr_red   = (ch > 18'd65535) ? 16'hFFFF : ch[15:0];
        1:       res14_d.irr_green = (ch > 18'd65535) ? 16'hFFFF : ch[15:0];
        default: res14_d.irr_blue  = (ch > 18'd65535) ? 16'hFFFF : ch[15:0];
      endcase
    end
    if (tl_q[TlN-1].degen) begin
      res14_d.dir_x = '0;
      res14_d.dir_y = '0;
      res14_d.dir_z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag1_d;
      neg1_q  <= neg1_d;
      dg1_q   <= item_i.degen;
      sq2_q   <= sq2_d;
      sa2_q   <= '{mag: mag1_q, neg: neg1_q, degen: dg1_q};
      x3_q    <= x3_d;
      sa3_q   <= sa2_q;
      dnum4_q <= dnum4_d;
      dden4_q <= rt_root_q[SqW-1];
      fnum4_q <= fnum4_d;
      fden4_q <= fden4_d;
      sb4_q   <= sb4_d;
      dv_side_q[0] <= sb4_q;
      for (int s = 1; s < DvW; s++) begin
        dv_side_q[s] <= dv_side_q[s-1];
      end
      tl_q[0] <= tl0_d;
      for (int s = 1; s < TlN; s++) begin
        tl_q[s] <= tl_q[s-1];
      end
      pr6_q   <= pr6_d;
      a7_q    <= a7_d;
      ck8_q   <= ck8_d;
      k8_q    <= k8_d;
      i8_q    <= i8_d;
      r8_q    <= r8_d;
      lg9_q   <= lg9_d;
      k9_q    <= k8_q;
      ck9_q   <= ck8_q;
      e10_q   <= e10_d;
      ck10_q  <= ck9_q;
      x11_q   <= x11_d;
      n11_q   <= n11_d;
      big11_q <= big11_d;
      ck11_q  <= ck10_q;
      g12_q   <= g12_d;
      att13_q <= att13_d;
      res14_q <= res14_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign res_o       = res14_q;

endmodule

>>> rtl/spot_light_attenuation.sv
// ----------------------------------------------------------------------------
// spot_light_attenuation
// Spot light with linear distance falloff and power-law cone, one surface
// point in, one light vector and irradiance out.
// ----------------------------------------------------------------------------
// Takes one surface point per clock while the input queue is not full, and
// returns one result per point, in order. The pipeline contains the 31-stage
// square root and the 16-stage dividers for the unit vector and the
// falloff. A 4-entry input queue and a 4-entry result queue let either
// side stall on its own; the pipeline holds while the result queue is
// full. Write configuration only while no point is in flight.
module spot_light_attenuation #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [19:0]        point_x_i,
  input  logic signed [19:0]        point_y_i,
  input  logic signed [19:0]        point_z_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [15:0]        dir_x_o,
  output logic signed [15:0]        dir_y_o,
  output logic signed [15:0]        dir_z_o,
  output logic [15:0]               irr_red_o,
  output logic [15:0]               irr_green_o,
  output logic [15:0]               irr_blue_o,
  output logic                      degenerate_o,
  input  logic                      cfg_we_i,
  input  logic [sla_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [sla_pkg::CfgW-1:0]  cfg_data_i
);

  logic [59:0]          light_pos_q;
  sla_pkg::cfg_t        cfg_q;
  sla_pkg::front_item_t front_item, mid_item;
  sla_pkg::res_item_t   back_res, out_res;
  logic                 mid_empty, out_full, en, back_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_pos_q          <= sla_pkg::LIGHT_POSITION_RST;
      cfg_q.light_color    <= sla_pkg::LIGHT_COLOR_RST;
      cfg_q.falloff_start  <= sla_pkg::FALLOFF_START_RST;
      cfg_q.falloff_end    <= sla_pkg::FALLOFF_END_RST;
      cfg_q.spot_direction <= sla_pkg::SPOT_DIRECTION_RST;
      cfg_q.spot_power     <= sla_pkg::SPOT_POWER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sla_pkg::REG_LIGHT_POSITION: light_pos_q          <= cfg_data_i[59:0];
        sla_pkg::REG_LIGHT_COLOR:    cfg_q.light_color    <= cfg_data_i[47:0];
        sla_pkg::REG_FALLOFF_START:  cfg_q.falloff_start  <= cfg_data_i[19:0];
        sla_pkg::REG_FALLOFF_END:    cfg_q.falloff_end    <= cfg_data_i[19:0];
        sla_pkg::REG_SPOT_DIRECTION: cfg_q.spot_direction <= cfg_data_i[47:0];
        sla_pkg::REG_SPOT_POWER:     cfg_q.spot_power     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  sla_front u_front (
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .light_pos_i (light_pos_q),
    .item_o      (front_item)
  );

  sla_fifo #(.DEPTH(MID_DEPTH), .WIDTH($bits(sla_pkg::front_item_t))) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (en),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  assign en = !out_full;

  sla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (!mid_empty),
    .item_i      (mid_item),
    .cfg_i       (cfg_q),
    .out_valid_o (back_valid),
    .res_o       (back_res)
  );

  sla_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(sla_pkg::res_item_t))) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && back_valid),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign dir_x_o      = out_res.dir_x;
  assign dir_y_o      = out_res.dir_y;
  assign dir_z_o      = out_res.dir_z;
  assign irr_red_o    = out_res.irr_red;
  assign irr_green_o  = out_res.irr_green;
  assign irr_blue_o   = out_res.irr_blue;
  assign degenerate_o = out_res.degenerate;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && degenerate_o) |-> (irr_red_o == 16'd0 && irr_green_o == 16'd0 &&
      irr_blue_o == 16'd0 && dir_x_o == 16'sd0 && dir_y_o == 16'sd0 && dir_z_o == 16'sd0))
    else $error("degenerate result carries nonzero data");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (dir_x_o <= 16'sd16384 && dir_x_o >= -16'sd16384 &&
      dir_y_o <= 16'sd16384 && dir_y_o >= -16'sd16384 &&
      dir_z_o <= 16'sd16384 && dir_z_o >= -16'sd16384))
    else $error("light vector component out of unit range");

  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !degenerate_o) |-> (dir_x_o != 16'sd0 || dir_y_o != 16'sd0 ||
      dir_z_o != 16'sd0))
    else $error("zero light vector on a regular point");
`endif

endmodule

>>> tb/sv/spot_light_attenuation_tb.sv
// ----------------------------------------------------------------------------
// spot_light_attenuation_tb
// Self-checking bench for the spot light block: points are pushed with random
// gaps, a bit-exact predictor computes the unit vector and irradiance of each
// point, and every popped word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module spot_light_attenuation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 100;
  localparam int PressureCycles = 400;
  localparam logic [sla_pkg::IdxW-1:0] RegNone = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [19:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] dir_x_o, dir_y_o, dir_z_o;
  logic [15:0] irr_red_o, irr_green_o, irr_blue_o;
  logic degenerate_o;
  logic cfg_we_i = 1'b0;
  logic [sla_pkg::IdxW-1:0] cfg_idx_i = '0;
  logic [sla_pkg::CfgW-1:0] cfg_data_i = '0;

  spot_light_attenuation dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [59:0] m_pos;
  logic [47:0] m_color;
  logic [19:0] m_start, m_end;
  logic [47:0] m_axis;
  logic [9:0]  m_power;

  sla_pkg::res_item_t shade_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit sink_busy = 1;

  localparam longint unsigned LogTab[17] = '{0, 5732, 11136, 16248, 21098, 25711,
    30110, 34313, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
  localparam longint unsigned ExpTab[17] = '{65536, 62757, 60097, 57549, 55109,
    52773, 50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
    32768};

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cone_power(longint unsigned a, longint unsigned p);
    longint unsigned m, k, i, r, lg, lv, e, n, f, j, s, x;
    if (p == 0) return 65536;
    if (a == 0) return 0;
    if (a >= 65536) return 65536;
    m = a;
    k = 0;
    while (m < 32768) begin
      m = m << 1;
      k++;
    end
    i = (m - 32768) >> 11;
    r = (m - 32768) & 2047;
    lg = LogTab[i] + (((LogTab[i+1] - LogTab[i]) * r + 1024) >> 11);
    lv = (k + 1) * 65536 - lg;
    e = (lv * p + 8) >> 4;
    n = e >> 16;
    f = e & 16'hFFFF;
    if (n > 16) return 0;
    j = f >> 12;
    s = f & 4095;
    x = ExpTab[j] - (((ExpTab[j] - ExpTab[j+1]) * s + 2048) >> 12);
    if (n == 0) return x;
    return (x + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic sla_pkg::res_item_t shade_point(logic signed [19:0] px,
                                                     logic signed [19:0] py,
                                                     logic signed [19:0] pz);
    sla_pkg::res_item_t res;
    longint v[3], dir[3], dot, t, u;
    longint unsigned mag[3], d2, q, d, fall, a, g, att, col, ch;
    logic signed [19:0] pt[3];
    logic signed [19:0] lp;
    logic signed [15:0] ax;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    res = '0;
    d2 = 0;
    dot = 0;
    for (int c = 0; c < 3; c++) begin
      lp = m_pos[20*c +: 20];
      v[c] = longint'(lp) - longint'(pt[c]);
      mag[c] = v[c] < 0 ? -v[c] : v[c];
      d2 += mag[c] * mag[c];
    end
    if (d2 == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    q = int_sqrt(d2 << 20);
    d = q >> 10;
    for (int c = 0; c < 3; c++) begin
      u = ((mag[c] << 24) + (q >> 1)) / q;
      if (u > 16384) u = 16384;
      dir[c] = v[c] < 0 ? -u : u;
      ax = m_axis[16*c +: 16];
      dot += longint'(ax) * dir[c];
    end
    res.dir_x = dir[0][15:0];
    res.dir_y = dir[1][15:0];
    res.dir_z = dir[2][15:0];
    if (d >= m_end) fall = 0;
    else if (d <= m_start) fall = 65536;
    else fall = 65536 - (((d - m_start) << 16) / (m_end - m_start));
    t = -dot;
    if (t <= 0) a = 0;
    else begin
      a = (t + 2048) >> 12;
      if (a > 65536) a = 65536;
    end
    g = cone_power(a, m_power);
    att = (g * fall + 32768) >> 16;
    for (int c = 0; c < 3; c++) begin
      col = m_color[16*c +: 16];
      ch = (col * att + 32768) >> 16;
      if (ch > 65535) ch = 65535;
      case (c)
        0: res.irr_red = ch[15:0];
        1: res.irr_green = ch[15:0];
        default: res.irr_blue = ch[15:0];
      endcase
    end
    return res;
  endfunction

  task automatic write_reg(logic [sla_pkg::IdxW-1:0] idx, logic [sla_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      sla_pkg::REG_LIGHT_POSITION: m_pos = val[59:0];
      sla_pkg::REG_LIGHT_COLOR:    m_color = val[47:0];
      sla_pkg::REG_FALLOFF_START:  m_start = val[19:0];
      sla_pkg::REG_FALLOFF_END:    m_end = val[19:0];
      sla_pkg::REG_SPOT_DIRECTION: m_axis = val[47:0];
      sla_pkg::REG_SPOT_POWER:     m_power = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (shade_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_coord(bit near, int axis);
    int pick;
    pick = $urandom_range(0, 9);
    if (near) return 20'($signed(m_pos[20*axis +: 20])) + 20'($urandom_range(0, 8000))
                     - 20'd4000;
    if (pick == 0) return 20'h80000;
    if (pick == 1) return 20'h7FFFF;
    return 20'($urandom);
  endfunction

  task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                            bit gaps = 1);
    int gap;
    if (gaps) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
          : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    push <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    shade_q.push_back(shade_point(px, py, pz));
    @(negedge clk_i);
  endtask

  task automatic send_rel(int dx, int dy, int dz);
    send_point(20'($signed(m_pos[19:0]) - dx), 20'($signed(m_pos[39:20]) - dy),
               20'($signed(m_pos[59:40]) - dz));
  endtask

  task automatic random_cfg();
    write_reg(sla_pkg::REG_LIGHT_POSITION,
              {$urandom_range(0, 3) == 0 ? 60'($urandom) : 60'd0} ^
              {4'd0, 20'($urandom_range(0, 4000)), 20'($urandom),
               20'($urandom_range(0, 9000))});
    write_reg(sla_pkg::REG_LIGHT_COLOR,
              {12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(sla_pkg::REG_FALLOFF_START, 20'($urandom_range(0, 4000)));
    write_reg(sla_pkg::REG_FALLOFF_END, $urandom_range(0, 5) == 0 ? 20'($urandom)
              : 20'($urandom_range(0, 30000)));
    write_reg(sla_pkg::REG_SPOT_DIRECTION,
              {12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(sla_pkg::REG_SPOT_POWER, 10'($urandom));
  endtask

  task automatic test_defaults();
    send_rel(0, 0, 0);
    send_rel(0, 0, -256);
    send_rel(0, 0, -2559);
    send_rel(0, 0, -2560);
    send_rel(100, 50, -700);
    send_rel(0, 0, 512);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
    wait_idle();
  endtask

  task automatic test_corners();
    write_reg(sla_pkg::REG_LIGHT_POSITION, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(sla_pkg::REG_LIGHT_COLOR, 48'hFFFF_FFFF_FFFF);
    write_reg(sla_pkg::REG_FALLOFF_START, 20'hFFFFF);
    write_reg(sla_pkg::REG_FALLOFF_END, 20'hFFFFF);
    write_reg(sla_pkg::REG_SPOT_DIRECTION, 48'h8000_8000_8000);
    write_reg(sla_pkg::REG_SPOT_POWER, 10'd0);
    send_rel(0, 0, 0);
    send_rel(100, -100, 3);
    send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
    wait_idle();
    write_reg(sla_pkg::REG_FALLOFF_START, 20'd3000);
    write_reg(sla_pkg::REG_FALLOFF_END, 20'd1000);
    write_reg(sla_pkg::REG_SPOT_POWER, 10'h3FF);
    write_reg(RegNone, 60'hFFF_FFFF_FFFF_FFFF);
    send_rel(512, 0, 0);
    send_rel(-5000, 0, 0);
    send_rel(0, 800, 0);
    wait_idle();
    write_reg(sla_pkg::REG_LIGHT_POSITION, 60'd0);
    write_reg(sla_pkg::REG_FALLOFF_START, 20'd0);
    write_reg(sla_pkg::REG_FALLOFF_END, 20'd0);
    write_reg(sla_pkg::REG_SPOT_DIRECTION, 48'h7FFF_7FFF_7FFF);
    send_rel(1, 1, 1);
    send_rel(-1, -1, -1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_cycles = PressureCycles;
    repeat (80) send_point(rand_coord(1, 0), rand_coord(1, 1), rand_coord(1, 2), 0);
    wait_idle();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      random_cfg();
      for (int n = 0; n < 115; n++) begin
        bit near;
        near = $urandom_range(0, 3) != 0;
        send_point(rand_coord(near, 0), rand_coord(near, 1), rand_coord(near, 2));
      end
      wait_idle();
    end
  endtask

  always @(negedge clk_i) begin
    if (sink_busy) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_cycles = $urandom_range(5, 40);
      pop <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    sla_pkg::res_item_t got, want;
    if (!rst_ni) begin
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && pop && !empty) begin
      got = '{dir_x_o, dir_y_o, dir_z_o, irr_red_o, irr_green_o, irr_blue_o, degenerate_o};
      if (shade_q.size() == 0) begin
        $display("%0t unexpected word %h", $realtime, got);
        errors++;
      end else begin
        want = shade_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %h actual %h", $realtime, want, got);
          errors++;
        end
      end
    end
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    m_pos = sla_pkg::LIGHT_POSITION_RST;
    m_color = sla_pkg::LIGHT_COLOR_RST;
    m_start = sla_pkg::FALLOFF_START_RST;
    m_end = sla_pkg::FALLOFF_END_RST;
    m_axis = sla_pkg::SPOT_DIRECTION_RST;
    m_power = sla_pkg::SPOT_POWER_RST;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    sink_busy = 0;
    @(negedge clk_i);
    test_defaults();
    test_corners();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0 && shade_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
